// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising edge of aclk, off while in reset.
`define AST_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check on the rising edge of aclk, off while in reset.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/slsc_pkg.sv
// ----------------------------------------------------------------------------
// slsc_pkg
// Shared types and constants of the lane steering core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slsc_pkg;

    // Arctangent table: atan(2^-i) in degrees, Q24
    localparam int unsigned TBL_FRAC = 24;
    localparam int unsigned TBL_LEN  = 24;
    localparam logic [31:0] ATAN_Q24 [TBL_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938,
        32'd60000935,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    // Configuration register indexes
    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;
    localparam logic [1:0] REG_LOST  = 2'd3;

    // Heading constants in tenths of a degree
    localparam logic signed [12:0] ANG_FULL = 13'sd1800;

    // floor(2^16 / 20) + 1: exact floor(m / 20) for m below 2^14
    localparam logic [11:0] RECIP20 = 12'd3277;

    // Per-item sideband that rides along the pipeline
    typedef struct packed {
        logic               neg;
        logic               inv;
        logic signed [12:0] head;
    } side_t;

endpackage

`default_nettype wire

// File: sv/slsc_div.sv
// ----------------------------------------------------------------------------
// slsc_div
// Pipelined restoring divider, one quotient bit per stage. The top
// NW-QW dividend bits must already be below the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slsc_div #(
    parameter int NW = 27,
    parameter int DW = 11,
    parameter int QW = 18,
    parameter int SW = 15
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QW-1:0]      quotient,
    output logic [SW-1:0]      out_side
);

    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] qr_reg    [QW];
    logic [DW-1:0] dvs_reg   [QW];
    logic [SW-1:0] side_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [DW:0]   cand;
        logic [DW:0]   trial;
        logic          fits;

        if (k == 0) begin : g_head
            assign v_in = in_valid;
            assign r_in = DW'(dividend[NW-1:QW]);
            assign q_in = dividend[QW-1:0];
            assign d_in = divisor;
            assign s_in = in_side;
        end else begin : g_body
            assign v_in = valid_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign q_in = qr_reg[k-1];
            assign d_in = dvs_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        // Trial subtract of the divisor from the shifted remainder
        assign cand  = {r_in, q_in[QW-1]};
        assign trial = cand - {1'b0, d_in};
        assign fits  = (cand >= {1'b0, d_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= fits ? trial[DW-1:0] : cand[DW-1:0];
                qr_reg[k]   <= {q_in[QW-2:0], fits};
                dvs_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quotient  = qr_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

// File: sv/slsc_cordic.sv
// ----------------------------------------------------------------------------
// slsc_cordic
// Pipelined CORDIC in vectoring mode, one micro-rotation per stage.
// Returns the accumulated angle in degrees, Q FRAC_BITS.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slsc_cordic #(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [FRAC_BITS+4:0]   mag,
    input  wire logic [SW-1:0]          in_side,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+7:0] angle,
    output logic [SW-1:0]               out_side
);

    import slsc_pkg::*;

    localparam int W = FRAC_BITS + 8;
    localparam int N = FRAC_BITS;

    logic          valid_reg [N];
    logic signed [W-1:0] x_reg [N];
    logic signed [W-1:0] y_reg [N];
    logic signed [W-1:0] z_reg [N];
    logic [SW-1:0] side_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic signed [W-1:0] STEP = W'(ATAN_Q24[k] >> (TBL_FRAC - FRAC_BITS));
        logic                v_in;
        logic signed [W-1:0] x_in;
        logic signed [W-1:0] y_in;
        logic signed [W-1:0] z_in;
        logic [SW-1:0]       s_in;

        if (k == 0) begin : g_head
            assign v_in = in_valid;
            assign x_in = W'(1) <<< FRAC_BITS;
            assign y_in = signed'(W'(mag));
            assign z_in = '0;
            assign s_in = in_side;
        end else begin : g_body
            assign v_in = valid_reg[k-1];
            assign x_in = x_reg[k-1];
            assign y_in = y_reg[k-1];
            assign z_in = z_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        // Rotate toward y = 0 and accumulate the angle
        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_in >= 0) begin
                    x_reg[k] <= x_in + (y_in >>> k);
                    y_reg[k] <= y_in - (x_in >>> k);
                    z_reg[k] <= z_in + STEP;
                end else begin
                    x_reg[k] <= x_in - (y_in >>> k);
                    y_reg[k] <= y_in + (x_in >>> k);
                    z_reg[k] <= z_in - STEP;
                end
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign angle     = z_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// File: sv/stanley_lane_steering_core.sv
// ----------------------------------------------------------------------------
// stanley_lane_steering_core
// Stanley lateral controller: lane distances and angles in, clamped
// steering angle in whole degrees out.
// ----------------------------------------------------------------------------
//  channel  | prefix | payload
//  ---------+--------+---------------------------------------------------
//  input    | s_     | left_dist, right_dist, left_angle, right_angle
//  result   | m_     | steering, velocity, invalid
//  config   | cfg_   | wr_en, addr, wdata (write only)
//
//  One transaction per cycle sustained while m_ready is high. Items flow
//  through the input stage, lateral divider, multiply, speed divider,
//  CORDIC, and the sum, scale and output stages.
//  The whole pipeline advances together; it halts only while a result
//  waits at the output and m_ready is low. Reset is synchronous, no
//  clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stanley_lane_steering_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [9:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [9:0]  s_left_dist,
    input  wire logic [9:0]  s_right_dist,
    input  wire logic [10:0] s_left_angle,
    input  wire logic [10:0] s_right_angle,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [7:0] m_steering,
    output logic [7:0]       m_velocity,
    output logic             m_invalid
);

    import slsc_pkg::*;

    localparam int SW  = $bits(side_t);
    localparam int LQW = FRAC_BITS + 2;
    localparam int XQW = FRAC_BITS + 5;
    localparam int PW  = FRAC_BITS + 18;
    localparam int TW  = FRAC_BITS + 15;

    // Configuration registers
    logic [9:0] gain_reg;
    logic [7:0] speed_reg;
    logic [6:0] limit_reg;
    logic [9:0] lost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= 10'd64;
            speed_reg <= 8'd20;
            limit_reg <= 7'd28;
            lost_reg  <= 10'd160;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GAIN:  gain_reg  <= cfg_wdata;
                REG_SPEED: speed_reg <= cfg_wdata[7:0];
                REG_LIMIT: limit_reg <= cfg_wdata[6:0];
                REG_LOST:  lost_reg  <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output is blocked
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Stage 0: distance sum, difference and heading
    logic [10:0]        sum_next;
    logic [9:0]         dd;
    logic signed [12:0] la_s;
    logic signed [12:0] ra_s;
    side_t              side0_next;

    assign sum_next = {1'b0, s_left_dist} + {1'b0, s_right_dist};
    assign dd       = (s_left_dist >= s_right_dist) ? s_left_dist - s_right_dist
                                                    : s_right_dist - s_left_dist;
    assign la_s     = signed'({2'b00, s_left_angle});
    assign ra_s     = signed'({2'b00, s_right_angle});

    always_comb begin
        side0_next.neg = (s_right_dist > s_left_dist);
        side0_next.inv = (sum_next == '0);
        if (s_left_dist == lost_reg) begin
            side0_next.head = ANG_FULL - (ra_s <<< 1);
        end else if (s_right_dist == lost_reg) begin
            side0_next.head = (la_s <<< 1) - ANG_FULL;
        end else begin
            side0_next.head = la_s + ra_s - ANG_FULL;
        end
    end

    logic        v0_reg;
    logic [10:0] sum_reg;
    logic [10:0] adiff_reg;
    side_t       side0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg   <= sum_next;
            adiff_reg <= {dd, 1'b0};
            side0_reg <= side0_next;
        end
    end

    // Lateral error magnitude: 2|l-r| * 2^F / (l+r)
    logic           v1;
    logic [LQW-1:0] lat;
    logic [SW-1:0]  side1;

    slsc_div #(
        .NW (FRAC_BITS + 11),
        .DW (11),
        .QW (LQW),
        .SW (SW)
    ) u_lat_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v0_reg),
        .dividend  ({adiff_reg, {FRAC_BITS{1'b0}}}),
        .divisor   (sum_reg),
        .in_side   (side0_reg),
        .out_valid (v1),
        .quotient  (lat),
        .out_side  (side1)
    );

    // Multiply by gain * 36
    logic [15:0]   gain36;
    logic          v2_reg;
    logic [PW-1:0] prod_reg;
    logic [SW-1:0] side2_reg;

    assign gain36 = ({6'd0, gain_reg} << 5) + ({6'd0, gain_reg} << 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= PW'(gain36) * PW'(lat);
            side2_reg <= side1;
        end
    end

    // Divide by 2560 * speed: drop 512 here, divide by 5 * speed below
    logic [7:0]     sp;
    logic [10:0]    sp5;
    logic           v3;
    logic [XQW-1:0] xmag;
    logic [SW-1:0]  side3;

    assign sp  = (speed_reg == '0) ? 8'd1 : speed_reg;
    assign sp5 = ({3'd0, sp} << 2) + {3'd0, sp};

    slsc_div #(
        .NW (FRAC_BITS + 9),
        .DW (11),
        .QW (XQW),
        .SW (SW)
    ) u_spd_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .dividend  (prod_reg[PW-1:9]),
        .divisor   (sp5),
        .in_side   (side2_reg),
        .out_valid (v3),
        .quotient  (xmag),
        .out_side  (side3)
    );

    // Arctangent in degrees, Q F; the zero flag rides with the side data
    logic                        v4;
    logic signed [FRAC_BITS+7:0] zang;
    logic [SW:0]                 side4;

    slsc_cordic #(
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW + 1)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3),
        .mag       (xmag),
        .in_side   ({xmag == '0, side3}),
        .out_valid (v4),
        .angle     (zang),
        .out_side  (side4)
    );

    // Stage: total = h * 2^F + 20 * atan (subtracted when neg is set), signed
    side_t              side4_s;
    logic [TW-1:0]      amag;
    logic [TW-1:0]      a20;
    logic signed [TW-1:0] total_next;

    assign side4_s = side_t'(side4[SW-1:0]);
    assign amag    = (side4[SW] || zang < 0) ? '0 : TW'(zang[FRAC_BITS+6:0]);
    assign a20     = (amag << 4) + (amag << 2);

    always_comb begin
        total_next = (TW'(side4_s.head) <<< FRAC_BITS);
        if (side4_s.neg) begin
            total_next = total_next - signed'(a20);
        end else begin
            total_next = total_next + signed'(a20);
        end
    end

    logic                 v5_reg;
    logic signed [TW-1:0] total_reg;
    logic                 inv5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            total_reg <= total_next;
            inv5_reg  <= side4_s.inv;
        end
    end

    // Stage: whole degrees by shift and reciprocal of 20
    logic [TW-1:0]         tabs;
    logic [TW-FRAC_BITS-1:0] tdeg;
    logic [26:0]           qprod;

    assign tabs  = (total_reg < 0) ? TW'(-total_reg) : TW'(total_reg);
    assign tdeg  = tabs[TW-1:FRAC_BITS];
    assign qprod = 27'(tdeg) * 27'(RECIP20);

    logic       v6_reg;
    logic [10:0] deg_reg;
    logic       neg6_reg;
    logic       inv6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            deg_reg  <= qprod[26:16];
            neg6_reg <= (total_reg < 0);
            inv6_reg <= inv5_reg;
        end
    end

    // Output register: clamp, apply sign, zero if invalid, hold while stalled
    logic [6:0]        clamp;
    logic signed [7:0] steer_next;
    logic signed [7:0] m_steering_reg;
    logic [7:0]        m_velocity_reg;
    logic              m_invalid_reg;

    assign clamp = (deg_reg > {4'd0, limit_reg}) ? limit_reg : deg_reg[6:0];

    always_comb begin
        if (inv6_reg) begin
            steer_next = '0;
        end else if (neg6_reg) begin
            steer_next = -signed'({1'b0, clamp});
        end else begin
            steer_next = signed'({1'b0, clamp});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_steering_reg <= steer_next;
            m_velocity_reg <= speed_reg;
            m_invalid_reg  <= inv6_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_steering = m_steering_reg;
    assign m_velocity = m_velocity_reg;
    assign m_invalid  = m_invalid_reg;

`include "assert_macros.svh"

    `AST_IMPLY(a_inv_zero, m_valid && m_invalid, m_steering == 8'sd0,
        "invalid result carries nonzero steering")
    `AST_IMPLY(a_clamp, m_valid && !m_invalid,
        (m_steering <= signed'({1'b0, limit_reg})) &&
        (m_steering >= -signed'({1'b0, limit_reg})),
        "steering outside the clamp limit")
    `AST_IMPLY(a_velocity, m_valid, m_velocity == speed_reg,
        "velocity does not echo the speed register")
    `AST_NEXT(a_stall_keep, m_valid && !m_ready, m_valid && (v6_reg == $past(v6_reg)),
        "pipeline moved while the output was blocked")

endmodule

`default_nettype wire
